// File: rtl/nrmc_pkg.sv
// Shared constants, character codes and fixed-point factors of the RMC position parser.
package nrmc_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned LAT_W     = 27;
	localparam int unsigned LON_W     = 28;

	// ASCII characters the parser reacts to
	localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
	localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_POINT  = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_0      = 8'h30;
	localparam logic [BYTE_W-1:0] CH_9      = 8'h39;
	localparam logic [BYTE_W-1:0] CH_A      = 8'h41;
	localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;

	// header match positions
	localparam logic [2:0] HDR_IDLE  = 3'd0;
	localparam logic [2:0] HDR_FIRST = 3'd1;
	localparam logic [2:0] HDR_LAST  = 3'd6;
	localparam logic [2:0] HDR_BAD   = 3'd7;

	// field numbers
	localparam logic [3:0] FIELD_STATUS = 4'd1;
	localparam logic [3:0] FIELD_LAT    = 4'd2;
	localparam logic [3:0] FIELD_LON    = 4'd4;
	localparam logic [3:0] FIELD_MAX    = 4'd15;

	localparam logic [2:0] STATUS_CNT_MAX = 3'd7;

	// integer parts of the coordinate fields
	localparam int unsigned LAT_WHOLE_W = 14;
	localparam int unsigned WHOLE_W     = 15;
	localparam int unsigned WMUL_W      = 19;
	localparam logic [WMUL_W-1:0] LAT_WHOLE_MAX = 19'd16383;
	localparam logic [WMUL_W-1:0] LON_WHOLE_MAX = 19'd32767;

	// lanes of the conversion pipeline
	localparam int unsigned NUM_LANES = 2;
	localparam int unsigned LANE_LAT  = 0;
	localparam int unsigned LANE_LON  = 1;

	// whole / 100 as multiply by reciprocal, exact for whole below 2^15
	localparam int unsigned DIV100_MUL   = 5243;
	localparam int unsigned DIV100_SHIFT = 19;
	localparam int unsigned PQ_W         = WHOLE_W + 13;
	localparam int unsigned QUO_W        = 9;
	localparam int unsigned REM_W        = 7;
	localparam int unsigned CENT         = 100;

	// minutes scaled to 1e-6 units stay below 1e8
	localparam int unsigned UDEG_PER_DEG = 1000000;
	localparam int unsigned QD_W         = 29;
	localparam int unsigned P_W          = 27;

	// P / 60 = (P >> 2) / 15, the divide by 15 by reciprocal, exact for 25-bit values
	localparam int unsigned DIV15_MUL   = 35791395;
	localparam int unsigned DIV15_SHIFT = 29;
	localparam int unsigned PROD15_W    = (P_W - 2) + 26;
	localparam int unsigned MD_W        = 21;

	localparam int unsigned SUM_W = 30;
	localparam logic [SUM_W-1:0] LAT_LIMIT = 30'd90000000;
	localparam logic [SUM_W-1:0] LON_LIMIT = 30'd180000000;

	function automatic logic [BYTE_W-1:0] hdr_char(input logic [2:0] pos);
		logic [BYTE_W-1:0] c;
		case (pos)
			3'd1:    c = 8'h47; // G
			3'd2:    c = 8'h50; // P
			3'd3:    c = 8'h52; // R
			3'd4:    c = 8'h4D; // M
			3'd5:    c = 8'h43; // C
			3'd6:    c = CH_COMMA;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	function automatic logic [SUM_W-1:0] lane_limit(input int unsigned lane);
		return (lane == LANE_LAT) ? LAT_LIMIT : LON_LIMIT;
	endfunction

endpackage

// File: rtl/nmea_rmc_position_parser.sv
// RMC sentence parser: byte-wise field tracking and a pipelined micro-degree conversion.
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------
//  in      | in_valid / in_stall | rx_byte
//  out     | out_valid/out_stall | latitude_udeg, longitude_udeg
//
// One byte is taken every cycle while in_stall is low; the parser state updates at the accepting edge.
// The result of a '*' enters the first stage as that byte is accepted, then moves on to the output register.
// The conversion runs through five stages plus the output register, one item each.
// in_stall rises only when every conversion stage and the output register are full
// and out_stall is high.
// Reset clears the parser state and all stage valid bits.
module nmea_rmc_position_parser #(
	parameter int unsigned FRAC_DIGITS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [nrmc_pkg::BYTE_W-1:0]   rx_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [nrmc_pkg::LAT_W-1:0]    latitude_udeg,
	output logic [nrmc_pkg::LON_W-1:0]    longitude_udeg
);
	import nrmc_pkg::*;

	localparam int unsigned FRAC_UNIT = 10 ** FRAC_DIGITS;
	localparam int unsigned FRAC_W    = $clog2(FRAC_UNIT);
	localparam int unsigned SCALE_K   = 10 ** (6 - FRAC_DIGITS);
	localparam logic [2:0]  FRAC_CNT_MAX = 3'(FRAC_DIGITS);

	// parser state
	logic [2:0]             hdr_pos_q;
	logic                   in_body_q;
	logic [3:0]             field_q;
	logic                   status_ok_q;
	logic                   after_point_q;
	logic [2:0]             frac_cnt_q;
	logic [LAT_WHOLE_W-1:0] lat_whole_q;
	logic [WHOLE_W-1:0]     lon_whole_q;
	logic [FRAC_W-1:0]      lat_frac_q;
	logic [FRAC_W-1:0]      lon_frac_q;

	// conversion pipeline
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_out;

	logic [WHOLE_W-1:0]  w_s1  [NUM_LANES];
	logic [FRAC_W-1:0]   f_s1  [NUM_LANES];
	logic [WHOLE_W-1:0]  w_s2  [NUM_LANES];
	logic [FRAC_W-1:0]   f_s2  [NUM_LANES];
	logic [PQ_W-1:0]     pq_s2 [NUM_LANES];
	logic [QUO_W-1:0]    q_s3  [NUM_LANES];
	logic [REM_W-1:0]    r_s3  [NUM_LANES];
	logic [FRAC_W-1:0]   f_s3  [NUM_LANES];
	logic [QD_W-1:0]     qd_s4 [NUM_LANES];
	logic [P_W-1:0]      p_s4  [NUM_LANES];
	logic [QD_W-1:0]     qd_s5 [NUM_LANES];
	logic [MD_W-1:0]     md_s5 [NUM_LANES];
	logic [LAT_W-1:0]    lat_q;
	logic [LON_W-1:0]    lon_q;

	logic [PROD15_W-1:0] prod15 [NUM_LANES];
	logic [SUM_W-1:0]    sum_c  [NUM_LANES];
	logic [SUM_W-1:0]    res_c  [NUM_LANES];

	logic                in_acc;
	logic                is_digit;
	logic [3:0]          digit;
	logic                emit;
	logic [WMUL_W-1:0]   lat_wmul, lon_wmul;
	logic [FRAC_W+3:0]   lat_fmul, lon_fmul;
	logic [FRAC_W-1:0]   lat_frac_pad, lon_frac_pad;

	// scale a short fraction up to the full digit count
	function automatic logic [FRAC_W-1:0] pad_frac(input logic [FRAC_W-1:0] f,
		input logic [2:0] cnt);
		logic [FRAC_W+3:0] r;
		r = {4'b0, f};
		for (int i = 0; i < FRAC_DIGITS; i++) begin
			if (3'(i) >= cnt)
				r = r * (FRAC_W+4)'(10);
		end
		return r[FRAC_W-1:0];
	endfunction

	assign adv_out = !out_valid_q || !out_stall;
	assign adv_s5  = !v_s5 || adv_out;
	assign adv_s4  = !v_s4 || adv_s5;
	assign adv_s3  = !v_s3 || adv_s4;
	assign adv_s2  = !v_s2 || adv_s3;
	assign adv_s1  = !v_s1 || adv_s2;

	assign in_stall = !adv_s1;
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		is_digit = rx_byte inside {[CH_0:CH_9]};
		digit    = rx_byte[3:0];
		lat_wmul = WMUL_W'(lat_whole_q) * WMUL_W'(10) + WMUL_W'(digit);
		lon_wmul = WMUL_W'(lon_whole_q) * WMUL_W'(10) + WMUL_W'(digit);
		lat_fmul = (FRAC_W+4)'(lat_frac_q) * (FRAC_W+4)'(10) + (FRAC_W+4)'(digit);
		lon_fmul = (FRAC_W+4)'(lon_frac_q) * (FRAC_W+4)'(10) + (FRAC_W+4)'(digit);
		lat_frac_pad = (field_q == FIELD_LAT) ? pad_frac(lat_frac_q, frac_cnt_q) : lat_frac_q;
		lon_frac_pad = (field_q == FIELD_LON) ? pad_frac(lon_frac_q, frac_cnt_q) : lon_frac_q;
		emit = in_acc && in_body_q && (rx_byte == CH_STAR) && status_ok_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q     <= HDR_IDLE;
			in_body_q     <= 1'b0;
			field_q       <= '0;
			status_ok_q   <= 1'b0;
			after_point_q <= 1'b0;
			frac_cnt_q    <= '0;
			lat_whole_q   <= '0;
			lon_whole_q   <= '0;
			lat_frac_q    <= '0;
			lon_frac_q    <= '0;
		end else if (in_acc) begin
			if (rx_byte == CH_DOLLAR) begin
				// restart the header match from anywhere
				in_body_q <= 1'b0;
				hdr_pos_q <= HDR_FIRST;
			end else if (!in_body_q) begin
				if (hdr_pos_q != HDR_IDLE && hdr_pos_q != HDR_BAD &&
					rx_byte == hdr_char(hdr_pos_q)) begin
					if (hdr_pos_q == HDR_LAST) begin
						in_body_q     <= 1'b1;
						hdr_pos_q     <= HDR_IDLE;
						field_q       <= '0;
						status_ok_q   <= 1'b0;
						after_point_q <= 1'b0;
						frac_cnt_q    <= '0;
						lat_whole_q   <= '0;
						lon_whole_q   <= '0;
						lat_frac_q    <= '0;
						lon_frac_q    <= '0;
					end else begin
						hdr_pos_q <= hdr_pos_q + 3'd1;
					end
				end else begin
					hdr_pos_q <= HDR_IDLE;
				end
			end else if (rx_byte == CH_STAR) begin
				in_body_q <= 1'b0;
				hdr_pos_q <= HDR_IDLE;
			end else if (rx_byte == CH_COMMA) begin
				lat_frac_q <= lat_frac_pad;
				lon_frac_q <= lon_frac_pad;
				if (field_q != FIELD_MAX)
					field_q <= field_q + 4'd1;
				after_point_q <= 1'b0;
				frac_cnt_q    <= '0;
			end else if (field_q == FIELD_STATUS) begin
				status_ok_q <= (frac_cnt_q == 3'd0) && (rx_byte == CH_A);
				if (frac_cnt_q != STATUS_CNT_MAX)
					frac_cnt_q <= frac_cnt_q + 3'd1;
			end else if (field_q == FIELD_LAT || field_q == FIELD_LON) begin
				if (rx_byte == CH_POINT) begin
					after_point_q <= 1'b1;
				end else if (is_digit) begin
					if (after_point_q) begin
						// drop digits past FRAC_DIGITS fraction digits
						if (frac_cnt_q < FRAC_CNT_MAX) begin
							frac_cnt_q <= frac_cnt_q + 3'd1;
							if (field_q == FIELD_LAT)
								lat_frac_q <= lat_fmul[FRAC_W-1:0];
							else
								lon_frac_q <= lon_fmul[FRAC_W-1:0];
						end
					end else if (field_q == FIELD_LAT) begin
						lat_whole_q <= (lat_wmul > LAT_WHOLE_MAX) ?
							LAT_WHOLE_MAX[LAT_WHOLE_W-1:0] : lat_wmul[LAT_WHOLE_W-1:0];
					end else begin
						lon_whole_q <= (lon_wmul > LON_WHOLE_MAX) ?
							LON_WHOLE_MAX[WHOLE_W-1:0] : lon_wmul[WHOLE_W-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1)
				v_s1 <= emit;
			if (adv_s2)
				v_s2 <= v_s1;
			if (adv_s3)
				v_s3 <= v_s2;
			if (adv_s4)
				v_s4 <= v_s3;
			if (adv_s5)
				v_s5 <= v_s4;
			if (adv_out)
				out_valid_q <= v_s5;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			prod15[i] = PROD15_W'(p_s4[i][P_W-1:2]) * PROD15_W'(DIV15_MUL);
			sum_c[i]  = SUM_W'(qd_s5[i]) + SUM_W'(md_s5[i]);
			res_c[i]  = (sum_c[i] > lane_limit(i)) ? lane_limit(i) : sum_c[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			w_s1[LANE_LAT] <= WHOLE_W'(lat_whole_q);
			w_s1[LANE_LON] <= lon_whole_q;
			f_s1[LANE_LAT] <= lat_frac_pad;
			f_s1[LANE_LON] <= lon_frac_pad;
		end
		for (int i = 0; i < NUM_LANES; i++) begin
			if (adv_s2) begin
				w_s2[i]  <= w_s1[i];
				f_s2[i]  <= f_s1[i];
				pq_s2[i] <= PQ_W'(w_s1[i]) * PQ_W'(DIV100_MUL);
			end
			if (adv_s3) begin
				q_s3[i] <= pq_s2[i][DIV100_SHIFT +: QUO_W];
				r_s3[i] <= REM_W'(16'(w_s2[i]) - 16'(pq_s2[i][DIV100_SHIFT +: QUO_W]) * 16'(CENT));
				f_s3[i] <= f_s2[i];
			end
			if (adv_s4) begin
				qd_s4[i] <= QD_W'(q_s3[i]) * QD_W'(UDEG_PER_DEG);
				p_s4[i]  <= P_W'(r_s3[i]) * P_W'(UDEG_PER_DEG) + P_W'(f_s3[i]) * P_W'(SCALE_K);
			end
			if (adv_s5) begin
				qd_s5[i] <= qd_s4[i];
				md_s5[i] <= prod15[i][DIV15_SHIFT +: MD_W];
			end
		end
		if (adv_out) begin
			lat_q <= res_c[LANE_LAT][LAT_W-1:0];
			lon_q <= res_c[LANE_LON][LON_W-1:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign latitude_udeg  = lat_q;
	assign longitude_udeg = lon_q;

endmodule

// File: rtl/nrmc_checker.sv
// Port-level checks for the RMC position parser and their binding to the top level.
module nrmc_port_checks (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [nrmc_pkg::LAT_W-1:0]  latitude_udeg,
	input logic [nrmc_pkg::LON_W-1:0]  longitude_udeg
);
	import nrmc_pkg::*;

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(latitude_udeg) &&
			$stable(longitude_udeg))
		else $error("result changed while stalled");

	// input backs up only when the whole conversion path is blocked at the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked result");

	a_lat_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> SUM_W'(latitude_udeg) <= LAT_LIMIT)
		else $error("latitude above limit");

	a_lon_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> SUM_W'(longitude_udeg) <= LON_LIMIT)
		else $error("longitude above limit");

endmodule

bind nmea_rmc_position_parser nrmc_port_checks u_nrmc_port_checks (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.latitude_udeg  (latitude_udeg),
	.longitude_udeg (longitude_udeg)
);
